// File: src/dwbw_pkg.sv
// ----------------------------------------------------------------------------
// dwbw_pkg
// Shared types and constants of the display window byte writer: channel
// items, the command word passed from front to back, and the queue size.
// ----------------------------------------------------------------------------
`default_nettype none

package dwbw_pkg;

  // Widest column and page indexes any configuration can use
  localparam int unsigned MAX_COL_W  = 8;
  localparam int unsigned MAX_PAGE_W = 4;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_WINDOW = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       last_in_packet;
    logic [7:0] col_from;
    logic [7:0] col_to;
    logic [7:0] page_from;
    logic [7:0] page_to;
    logic [6:0] read_col;
    logic [2:0] read_page;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       window_done;
    logic [6:0] cursor_col;
    logic [2:0] cursor_page;
  } out_item_t;

  // Classified command: bounds carry their own in-range flags
  typedef struct packed {
    op_t                   op;
    logic [7:0]            data;
    logic                  last;
    logic [MAX_COL_W-1:0]  col_from;
    logic                  col_from_ok;
    logic [MAX_COL_W-1:0]  col_to;
    logic                  col_to_ok;
    logic [MAX_PAGE_W-1:0] page_from;
    logic                  page_from_ok;
    logic [MAX_PAGE_W-1:0] page_to;
    logic                  page_to_ok;
    logic [MAX_COL_W-1:0]  rd_col;
    logic [MAX_PAGE_W-1:0] rd_page;
    logic                  rd_ok;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/dwbw_ram.sv
// ----------------------------------------------------------------------------
// dwbw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dwbw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/dwbw_front.sv
// ----------------------------------------------------------------------------
// dwbw_front
// Input side: takes items, decodes the function and range-checks window
// bounds and read coordinates, then pushes a command into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dwbw_front #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  wire logic               in_valid,
  input  wire dwbw_pkg::in_item_t in_item,
  output logic                    in_stall,
  input  wire logic               q_full,
  input  wire logic               back_busy,
  output logic                    push,
  output dwbw_pkg::cmd_t          push_cmd
);

  import dwbw_pkg::*;

  localparam logic [8:0] COL_LIM  = 9'(COLUMNS);
  localparam logic [8:0] PAGE_LIM = 9'(PAGES);

  assign in_stall = q_full || back_busy;
  assign push     = in_valid && !in_stall;

  always_comb begin
    push_cmd              = '0;
    push_cmd.op           = op_t'(in_item.func);
    push_cmd.data         = in_item.data_byte;
    push_cmd.last         = in_item.last_in_packet;
    push_cmd.col_from     = in_item.col_from;
    push_cmd.col_from_ok  = {1'b0, in_item.col_from} < COL_LIM;
    push_cmd.col_to       = in_item.col_to;
    push_cmd.col_to_ok    = {1'b0, in_item.col_to} < COL_LIM;
    push_cmd.page_from    = in_item.page_from[MAX_PAGE_W-1:0];
    push_cmd.page_from_ok = {1'b0, in_item.page_from} < PAGE_LIM;
    push_cmd.page_to      = in_item.page_to[MAX_PAGE_W-1:0];
    push_cmd.page_to_ok   = {1'b0, in_item.page_to} < PAGE_LIM;
    push_cmd.rd_col       = MAX_COL_W'(in_item.read_col);
    push_cmd.rd_page      = MAX_PAGE_W'(in_item.read_page);
    push_cmd.rd_ok        = (9'(in_item.read_col) < COL_LIM) &&
                            (9'(in_item.read_page) < PAGE_LIM);
  end

endmodule

`default_nettype wire

// File: src/dwbw_queue.sv
// ----------------------------------------------------------------------------
// dwbw_queue
// Short command FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dwbw_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dwbw_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output dwbw_pkg::cmd_t      head_cmd
);

  import dwbw_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full       = count_r == (QPTR_W+1)'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: src/dwbw_back.sv
// ----------------------------------------------------------------------------
// dwbw_back
// Execution side: window and cursor state, the frame store, the clearing
// sweep, and the result pipeline with its output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dwbw_back #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire dwbw_pkg::cmd_t q_cmd,
  output logic                q_pop,
  output logic                busy,
  output logic                out_valid,
  input  wire logic           out_stall,
  output dwbw_pkg::out_item_t out_item
);

  import dwbw_pkg::*;

  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned DEPTH = COLUMNS * PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned AXW   = AW + 1;

  localparam logic [CW-1:0] COL_LAST_RST  = CW'(COLUMNS - 1);
  localparam logic [PW-1:0] PAGE_LAST_RST = PW'(PAGES - 1);
  localparam logic [AW-1:0] SWEEP_LAST    = AW'(DEPTH - 1);
  localparam logic [AXW-1:0] COL_STRIDE   = AXW'(COLUMNS);

  // Window, cursor and drop state
  logic [CW-1:0] win_col_first_r,  win_col_first_nxt;
  logic [CW-1:0] win_col_last_r,   win_col_last_nxt;
  logic [PW-1:0] win_page_first_r, win_page_first_nxt;
  logic [PW-1:0] win_page_last_r,  win_page_last_nxt;
  logic [CW-1:0] cur_col_r,        cur_col_nxt;
  logic [PW-1:0] cur_page_r,       cur_page_nxt;
  logic          drop_r,           drop_nxt;

  // Clearing sweep
  logic          sweep_r,     sweep_nxt;
  logic [AW-1:0] sweep_cnt_r, sweep_cnt_nxt;

  // Result pipeline
  logic      pend_valid_r, pend_valid_nxt;
  out_item_t pend_res_r,   pend_res_nxt;
  logic      pend_rd_r,    pend_rd_nxt;
  logic      out_valid_r,  out_valid_nxt;
  out_item_t out_item_r,   out_item_nxt;

  logic          o_free, pend_adv, pend_free;
  logic [CW:0]   col_inc;
  logic [PW:0]   page_inc;
  logic [AXW-1:0] wr_addr_full, rd_addr_full;
  logic          done;
  logic [7:0]    col8;
  logic [3:0]    page4;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  dwbw_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign o_free    = !out_valid_r || !out_stall;
  assign pend_adv  = pend_valid_r && o_free;
  assign pend_free = !pend_valid_r || pend_adv;
  assign q_pop     = q_valid && pend_free && !sweep_r;
  assign busy      = sweep_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign col_inc      = {1'b0, cur_col_r} + 1'b1;
  assign page_inc     = {1'b0, cur_page_r} + 1'b1;
  assign wr_addr_full = AXW'(cur_page_r) * COL_STRIDE + AXW'(cur_col_r);
  assign rd_addr_full = AXW'(q_cmd.rd_page[PW-1:0]) * COL_STRIDE +
                        AXW'(q_cmd.rd_col[CW-1:0]);

  always_comb begin
    win_col_first_nxt  = win_col_first_r;
    win_col_last_nxt   = win_col_last_r;
    win_page_first_nxt = win_page_first_r;
    win_page_last_nxt  = win_page_last_r;
    cur_col_nxt        = cur_col_r;
    cur_page_nxt       = cur_page_r;
    drop_nxt           = drop_r;
    sweep_nxt          = sweep_r;
    sweep_cnt_nxt      = sweep_cnt_r;
    pend_valid_nxt     = pend_valid_r;
    pend_res_nxt       = pend_res_r;
    pend_rd_nxt        = pend_rd_r;
    out_valid_nxt      = out_valid_r;
    out_item_nxt       = out_item_r;
    done               = 1'b0;
    ram_we             = 1'b0;
    ram_waddr          = wr_addr_full[AW-1:0];
    ram_wdata          = q_cmd.data;
    ram_re             = 1'b0;

    // Zero one store entry per cycle
    if (sweep_r) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt_r;
      ram_wdata = '0;
      if (sweep_cnt_r == SWEEP_LAST) begin
        sweep_nxt = 1'b0;
      end else begin
        sweep_cnt_nxt = sweep_cnt_r + 1'b1;
      end
    end

    if (q_pop) begin
      pend_rd_nxt = 1'b0;
      case (q_cmd.op)
        OP_WRITE: begin
          if (drop_r) begin
            if (q_cmd.last) begin
              drop_nxt = 1'b0;
            end
          end else begin
            ram_we = 1'b1;
            if (col_inc > {1'b0, win_col_last_r}) begin
              cur_col_nxt = win_col_first_r;
              if (page_inc > {1'b0, win_page_last_r}) begin
                cur_page_nxt = win_page_first_r;
                done         = 1'b1;
                drop_nxt     = !q_cmd.last;
              end else begin
                cur_page_nxt = page_inc[PW-1:0];
              end
            end else begin
              cur_col_nxt = col_inc[CW-1:0];
            end
          end
        end
        OP_WINDOW: begin
          if (q_cmd.col_from_ok) begin
            win_col_first_nxt = q_cmd.col_from[CW-1:0];
          end
          if (q_cmd.col_to_ok) begin
            win_col_last_nxt = q_cmd.col_to[CW-1:0];
          end
          if (q_cmd.page_from_ok) begin
            win_page_first_nxt = q_cmd.page_from[PW-1:0];
          end
          if (q_cmd.page_to_ok) begin
            win_page_last_nxt = q_cmd.page_to[PW-1:0];
          end
          cur_col_nxt  = win_col_first_nxt;
          cur_page_nxt = win_page_first_nxt;
          drop_nxt     = 1'b0;
        end
        OP_CLEAR: begin
          cur_col_nxt   = win_col_first_r;
          cur_page_nxt  = win_page_first_r;
          drop_nxt      = 1'b0;
          sweep_nxt     = 1'b1;
          sweep_cnt_nxt = '0;
        end
        OP_READ: begin
          ram_re      = 1'b1;
          pend_rd_nxt = q_cmd.rd_ok;
        end
        default: begin
        end
      endcase
    end

    col8  = 8'(cur_col_nxt);
    page4 = 4'(cur_page_nxt);

    // Advance the result pipeline
    if (q_pop) begin
      pend_valid_nxt           = 1'b1;
      pend_res_nxt.read_data   = '0;
      pend_res_nxt.window_done = done;
      pend_res_nxt.cursor_col  = col8[6:0];
      pend_res_nxt.cursor_page = page4[2:0];
    end else if (pend_adv) begin
      pend_valid_nxt = 1'b0;
    end

    if (pend_adv) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt           = pend_res_r;
      out_item_nxt.read_data = pend_rd_r ? ram_rdata : 8'd0;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_col_first_r  <= '0;
      win_col_last_r   <= COL_LAST_RST;
      win_page_first_r <= '0;
      win_page_last_r  <= PAGE_LAST_RST;
      cur_col_r        <= '0;
      cur_page_r       <= '0;
      drop_r           <= 1'b0;
      sweep_r          <= 1'b1;
      sweep_cnt_r      <= '0;
      pend_valid_r     <= 1'b0;
      pend_rd_r        <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      win_col_first_r  <= win_col_first_nxt;
      win_col_last_r   <= win_col_last_nxt;
      win_page_first_r <= win_page_first_nxt;
      win_page_last_r  <= win_page_last_nxt;
      cur_col_r        <= cur_col_nxt;
      cur_page_r       <= cur_page_nxt;
      drop_r           <= drop_nxt;
      sweep_r          <= sweep_nxt;
      sweep_cnt_r      <= sweep_cnt_nxt;
      pend_valid_r     <= pend_valid_nxt;
      pend_rd_r        <= pend_rd_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_res_r <= pend_res_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire

// File: src/display_window_byte_writer_unit.sv
// ----------------------------------------------------------------------------
// display_window_byte_writer_unit
// Page-organized display framebuffer with a write window and a cursor.
// ----------------------------------------------------------------------------
// Path: command queue, then pending result register, then output register.
// Throughput: one item per cycle while in_stall is low; the command queue
//   keeps taking items while the output stalls, until the queue is full.
// Clear: the store is zeroed by a sweep over all COLUMNS*PAGES entries
//   (1024 by default, one entry a cycle through the single RAM write port),
//   during which in_stall is high.
// Reset: window spans the full display, cursor at origin, and the same
//   zeroing sweep runs right after reset before the first item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module display_window_byte_writer_unit #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire dwbw_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dwbw_pkg::out_item_t      out_item
);

  import dwbw_pkg::*;

  // Front to queue
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // Queue to back
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // Back is sweeping the store: hold the input side
  logic back_busy;

  // Decode each item and range-check its bounds before queueing
  dwbw_front #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_front (
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .back_busy (back_busy),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Short FIFO so the front keeps taking items while the back waits on
  // the output side
  dwbw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  // Carry out commands: cursor walk, window update, store access, clear
  dwbw_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
